// File: rtl/core/rtty_pkg.sv
// rtty_pkg: shared types and constants of the rtty fsk character transmitter
// used by the front, queue, back and top level files; no dependencies
`default_nettype none

package rtty_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CODE_W  = 8;
  localparam int BASE_W  = 24;
  localparam int SHIFT_W = 16;
  localparam int FREQ_W  = 25;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef enum logic [1:0] {
    MODE_ASCII7 = 2'd0,
    MODE_ASCII8 = 2'd1,
    MODE_ITA2   = 2'd2,
    MODE_BAD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_LETTERS = 2'd1,
    CLS_FIGURES = 2'd2,
    CLS_BAD     = 2'd3
  } char_class_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_STOP  = 2'd1,
    REG_BASE  = 2'd2,
    REG_SHIFT = 2'd3
  } reg_index_t;

  localparam logic [4:0] ITA2_FIGS = 5'b11011;
  localparam logic [4:0] ITA2_LTRS = 5'b11111;
  localparam logic [4:0] CODE_MASK = 5'b11111;

  localparam logic [3:0] NBITS_ASCII7 = 4'd7;
  localparam logic [3:0] NBITS_ASCII8 = 4'd8;
  localparam logic [3:0] NBITS_ITA2   = 4'd5;

  // up to three codes that one character turns into
  typedef struct packed {
    logic [CODE_W-1:0] code0;
    logic [CODE_W-1:0] code1;
    logic [CODE_W-1:0] code2;
    logic [1:0]        ncodes;
    logic [3:0]        nbits;
  } frame_set_t;

  typedef struct packed {
    logic [1:0]         stop_bits;
    logic [BASE_W-1:0]  base;
    logic [SHIFT_W-1:0] shift;
  } tx_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/rtty_front.sv
// rtty_front: accepts characters and turns each into a set of frame codes
// keeps the ita2 figures-shift flag; depends on rtty_pkg
`default_nettype none

module rtty_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rtty_pkg::mode_t            mode,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rtty_pkg::CODE_W-1:0] char_code,
  input  wire logic [1:0]                 char_class,
  input  wire logic                       last_in_message,
  input  wire logic                       q_full,
  output logic                            q_push,
  output rtty_pkg::frame_set_t            q_data
);

  logic in_figures;
  logic in_figures_next;

  logic [rtty_pkg::CODE_W-1:0] code_list [3];
  logic [1:0]                  n;
  logic                        fig;
  logic [rtty_pkg::CODE_W-1:0] ita2_code;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    code_list[0] = '0;
    code_list[1] = '0;
    code_list[2] = '0;
    n            = 2'd0;
    fig          = in_figures;
    ita2_code    = {3'b000, char_code[4:0] & rtty_pkg::CODE_MASK};
    q_data       = '0;
    unique case (mode)
      rtty_pkg::MODE_ASCII7: begin
        code_list[0] = char_code;
        n            = 2'd1;
        q_data.nbits = rtty_pkg::NBITS_ASCII7;
      end
      rtty_pkg::MODE_ASCII8: begin
        code_list[0] = char_code;
        n            = 2'd1;
        q_data.nbits = rtty_pkg::NBITS_ASCII8;
      end
      default: begin
        q_data.nbits = rtty_pkg::NBITS_ITA2;
        unique case (rtty_pkg::char_class_t'(char_class))
          rtty_pkg::CLS_FIGURES: begin
            if (!fig) begin
              code_list[0] = {3'b000, rtty_pkg::ITA2_FIGS};
              n            = 2'd1;
              fig          = 1'b1;
            end
            code_list[n] = ita2_code;
            n            = n + 2'd1;
          end
          rtty_pkg::CLS_LETTERS: begin
            if (fig) begin
              code_list[0] = {3'b000, rtty_pkg::ITA2_LTRS};
              n            = 2'd1;
              fig          = 1'b0;
            end
            code_list[n] = ita2_code;
            n            = n + 2'd1;
          end
          default: begin
            // unknown character sends code zero, shift untouched
            code_list[0] = '0;
            n            = 2'd1;
          end
        endcase
        if (last_in_message && fig) begin
          code_list[n] = {3'b000, rtty_pkg::ITA2_LTRS};
          n            = n + 2'd1;
          fig          = 1'b0;
        end
      end
    endcase
    q_data.code0  = code_list[0];
    q_data.code1  = code_list[1];
    q_data.code2  = code_list[2];
    q_data.ncodes = n;
    in_figures_next = (q_push && mode == rtty_pkg::MODE_ITA2) ? fig : in_figures;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_figures <= 1'b0;
    end else begin
      in_figures <= in_figures_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtty_queue.sv
// rtty_queue: short fifo of frame sets between front and back
// depends on rtty_pkg
`default_nettype none

module rtty_queue #(
  parameter int DEPTH = rtty_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire rtty_pkg::frame_set_t push_data,
  output logic                      full,
  output logic                      not_empty,
  input  wire logic                 pop,
  output rtty_pkg::frame_set_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtty_pkg::frame_set_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtty_back.sv
// rtty_back: one fsk symbol per cycle while not stalled, from queued
// frame sets: start bit, data lsb first, stop bits; depends on rtty_pkg
`default_nettype none

module rtty_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rtty_pkg::tx_cfg_t            cfg,
  input  wire logic                         q_not_empty,
  input  wire rtty_pkg::frame_set_t         q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              tone_is_mark,
  output logic [rtty_pkg::FREQ_W-1:0]       freq_word,
  output logic                              last_symbol
);

  logic [1:0] code_idx;
  logic [3:0] pos;
  logic [1:0] code_idx_next;
  logic [3:0] pos_next;

  logic                        advance;
  logic                        take;
  logic [rtty_pkg::CODE_W-1:0] cur_code;
  logic [3:0]                  frame_len;
  logic [3:0]                  data_idx;
  logic                        frame_end;
  logic                        set_end;
  logic                        mark;
  logic [rtty_pkg::FREQ_W-1:0] freq;

  assign advance = !out_valid || !out_stall;
  assign take    = advance && q_not_empty;

  always_comb begin
    unique case (code_idx)
      2'd0:    cur_code = q_head.code0;
      2'd1:    cur_code = q_head.code1;
      default: cur_code = q_head.code2;
    endcase
    frame_len = 4'd1 + q_head.nbits + {2'b00, cfg.stop_bits};
    data_idx  = pos - 4'd1;
    frame_end = (pos == frame_len - 4'd1);
    set_end   = frame_end && (code_idx == q_head.ncodes - 2'd1);
    if (pos == 4'd0) begin
      mark = 1'b0;
    end else if (pos <= q_head.nbits) begin
      mark = cur_code[data_idx[2:0]];
    end else begin
      mark = 1'b1;
    end
    freq = {1'b0, cfg.base} +
           (mark ? {{(rtty_pkg::FREQ_W - rtty_pkg::SHIFT_W){1'b0}}, cfg.shift} : '0);
    q_pop = take && set_end;
    if (!take) begin
      code_idx_next = code_idx;
      pos_next      = pos;
    end else if (set_end) begin
      code_idx_next = 2'd0;
      pos_next      = 4'd0;
    end else if (frame_end) begin
      code_idx_next = code_idx + 2'd1;
      pos_next      = 4'd0;
    end else begin
      code_idx_next = code_idx;
      pos_next      = pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_idx  <= 2'd0;
      pos       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      code_idx <= code_idx_next;
      pos      <= pos_next;
      if (advance) begin
        out_valid <= q_not_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tone_is_mark <= mark;
      freq_word    <= freq;
      last_symbol  <= set_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtty_fsk_char_transmitter_unit.sv
// rtty fsk character transmitter: one character in, a stream of fsk bit symbols out
// Input channel: in_valid / in_stall with char_code, char_class, last_in_message.
// Output channel: out_valid / out_stall with tone_is_mark, freq_word, last_symbol;
// each transaction is one bit period, last_symbol marks the final one of a character.
// A character becomes one to three codes (ita2 shift codes added as needed), each
// framed as a space start bit, 5/7/8 data bits lsb first and the stop bits.
// An accepted character is written into the queue; the back then loads its first
// symbol into the output register, where it is held while the receiver stalls.
// Throughput: one symbol per cycle while the receiver does not stall; each code
// is sent as start bit, data bits and stop bits; the back serializer sets the rate.
// The front classifies characters into a small queue and keeps taking them while
// the back is busy, stalling only when the queue is full.
// Reset empties the queue, clears the output valid flag and the figures flag, and
// loads the register defaults (ita2, one stop bit, base and shift zero).
// When the receiver stalls, the current symbol holds and the queue fills up.
// Registers on the apb port: 0 mode, 4 stop bits, 8 base word, 12 shift steps.
// depends on rtty_pkg, rtty_front, rtty_queue, rtty_back
`default_nettype none

module rtty_fsk_char_transmitter_unit #(
  parameter int QUEUE_DEPTH = rtty_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rtty_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rtty_pkg::DATA_W-1:0]   pwdata,
  output logic [rtty_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rtty_pkg::CODE_W-1:0]   char_code,
  input  wire logic [1:0]                    char_class,
  input  wire logic                          last_in_message,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               tone_is_mark,
  output logic [rtty_pkg::FREQ_W-1:0]        freq_word,
  output logic                               last_symbol
);

  rtty_pkg::mode_t              mode;
  logic [1:0]                   stop_bits;
  logic [rtty_pkg::BASE_W-1:0]  base;
  logic [rtty_pkg::SHIFT_W-1:0] shift;

  logic                 wr_en;
  rtty_pkg::reg_index_t reg_sel;
  rtty_pkg::tx_cfg_t    cfg;

  logic                 q_push;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  rtty_pkg::frame_set_t q_data;
  rtty_pkg::frame_set_t q_head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = rtty_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= rtty_pkg::MODE_ITA2;
      stop_bits <= 2'd1;
      base      <= '0;
      shift     <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        rtty_pkg::REG_MODE: begin
          // undefined mode code is dropped
          if (pwdata[1:0] != rtty_pkg::MODE_BAD) begin
            mode <= rtty_pkg::mode_t'(pwdata[1:0]);
          end
        end
        rtty_pkg::REG_STOP:  stop_bits <= pwdata[1:0];
        rtty_pkg::REG_BASE:  base      <= pwdata[rtty_pkg::BASE_W-1:0];
        rtty_pkg::REG_SHIFT: shift     <= pwdata[rtty_pkg::SHIFT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rtty_pkg::REG_MODE:  prdata = {30'd0, mode};
      rtty_pkg::REG_STOP:  prdata = {30'd0, stop_bits};
      rtty_pkg::REG_BASE:  prdata = {8'd0, base};
      rtty_pkg::REG_SHIFT: prdata = {16'd0, shift};
    endcase
  end

  assign cfg.stop_bits = stop_bits;
  assign cfg.base      = base;
  assign cfg.shift     = shift;

  rtty_front u_front (
    .clk             (clk),
    .rst             (rst),
    .mode            (mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .char_code       (char_code),
    .char_class      (char_class),
    .last_in_message (last_in_message),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  rtty_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  rtty_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tone_is_mark (tone_is_mark),
    .freq_word    (freq_word),
    .last_symbol  (last_symbol)
  );

endmodule

`default_nettype wire

// File: rtl/core/rtty_checker.sv
// rtty_checker: port-level assertions for the rtty fsk character transmitter
// bound to rtty_fsk_char_transmitter_unit; depends on rtty_pkg
`default_nettype none

module rtty_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        tone_is_mark,
  input wire logic [rtty_pkg::FREQ_W-1:0] freq_word,
  input wire logic                        last_symbol
);

  // a stalled symbol stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_is_mark) &&
                               $stable(freq_word) && $stable(last_symbol))
    else $error("stalled output symbol changed");

  // the symbol right after a character's last one is a start bit
  a_start_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid && !out_stall && last_symbol) |-> !tone_is_mark)
    else $error("frame did not open with a space start bit");

  // reset leaves no symbol pending
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // queue is empty after reset so the front takes a character
  a_reset_in: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind rtty_fsk_char_transmitter_unit rtty_checker u_rtty_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .tone_is_mark (tone_is_mark),
  .freq_word    (freq_word),
  .last_symbol  (last_symbol)
);

`default_nettype wire
